@@ rtl/median_filter_5x5_rgb_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef MEDIAN_FILTER_5X5_RGB_MACROS_SVH
`define MEDIAN_FILTER_5X5_RGB_MACROS_SVH

// implication checked at every rising clock edge, off while in reset
`define MF5_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define MF5_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mf5_pkg.sv @@
// ----------------------------------------------------------------------------
// mf5_pkg
// types, constants and sort network helpers for the 5x5 rgb median filter
// ----------------------------------------------------------------------------
`default_nettype none

package mf5_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int WIN_SIZE       = 25;
    localparam int SORT_N         = 32;
    localparam int SORT_STAGES    = 15;
    localparam int MEDIAN_RANK    = 12;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_W          = 13;
    localparam int WIDTH_REG_W    = 11;
    localparam int HEIGHT_REG_W   = 13;
    localparam int LINE_ROWS      = 4;

    localparam logic [7:0]  PAD_VALUE     = 8'hFF;
    localparam logic [10:0] WIDTH_RESET   = 11'd640;
    localparam logic [12:0] HEIGHT_RESET  = 13'd480;

    // register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef logic [23:0] pix_t;
    typedef logic [SORT_N-1:0][7:0] vec_t;
    typedef vec_t [2:0] rgb_vec_t;

    typedef struct packed {
        pix_t [WIN_SIZE-1:0] win;
        logic                last;
    } win_item_t;

    // merge size of one layer of the odd-even merge network
    function automatic int stage_p(int s);
        int cnt;
        int p;
        int k;
        int res;
        cnt = 0;
        res = 1;
        for (p = 1; p < SORT_N; p = p * 2) begin
            for (k = p; k >= 1; k = k / 2) begin
                if (cnt == s) res = p;
                cnt++;
            end
        end
        return res;
    endfunction

    // compare distance of one layer
    function automatic int stage_k(int s);
        int cnt;
        int p;
        int k;
        int res;
        cnt = 0;
        res = 1;
        for (p = 1; p < SORT_N; p = p * 2) begin
            for (k = p; k >= 1; k = k / 2) begin
                if (cnt == s) res = k;
                cnt++;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/median_filter_5x5_rgb.sv @@
// ----------------------------------------------------------------------------
// median_filter_5x5_rgb
// 5x5 per-channel median filter over a border-extended rgb raster stream
// ----------------------------------------------------------------------------
// Takes one extended pixel per clock while the window queue has room and
// gives one median pixel per clock once the window is full, unless m_ready
// holds the output; the rate is set by the line store, one read and one write
// per line ram each cycle. A pixel's result passes through the line store read
// and window update register, the window queue, then the sort pipe load
// register and 15 compare layers, the last of which drives the outputs. The
// line store holds no reset contents, so the block is ready right after reset.
// Register writes restart the frame at row and column zero.
`default_nettype none

module median_filter_5x5_rgb
    import mf5_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_red_in,
    input  wire logic [7:0]       s_green_in,
    input  wire logic [7:0]       s_blue_in,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_red_out,
    output logic [7:0]            m_green_out,
    output logic [7:0]            m_blue_out,
    output logic                  m_last_pixel
);

    logic                                 push, pop, q_valid;
    win_item_t                            push_item, q_item;
    logic [$clog2(QUEUE_DEPTH+1)-1:0]     q_count;

    mf5_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_red_in  (s_red_in),
        .s_green_in(s_green_in),
        .s_blue_in (s_blue_in),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    mf5_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_count  (q_count)
    );

    mf5_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_last_pixel(m_last_pixel)
    );

endmodule

`default_nettype wire

@@ rtl/mf5_ram.sv @@
// ----------------------------------------------------------------------------
// mf5_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mf5_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1028
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/mf5_front.sv @@
// ----------------------------------------------------------------------------
// mf5_front
// raster counters, line store and 5x5 window; pushes full windows to the queue
// ----------------------------------------------------------------------------
`default_nettype none

module mf5_front
    import mf5_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_index,
    input  wire logic [CFG_W-1:0]                 cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_red_in,
    input  wire logic [7:0]                       s_green_in,
    input  wire logic [7:0]                       s_blue_in,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                                  push,
    output win_item_t                             push_item
);

    `include "median_filter_5x5_rgb_macros.svh"

    localparam int LINE_LEN = MAX_WIDTH + 4;
    localparam int COL_W    = $clog2(LINE_LEN);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 4);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [COL_W-1:0]        width_cl;
    logic [ROW_W-1:0]        height_cl;
    logic                    accept;
    logic                    col_last, row_last;

    logic                    s1_valid_reg;
    logic                    s1_emit_reg;
    logic                    s1_last_reg;
    logic [COL_W-1:0]        s1_col_reg;
    pix_t                    s1_pix_reg;

    pix_t                    colv [LINE_ROWS+1];
    pix_t [WIN_SIZE-1:0]     win_reg, win_next;

    always_comb begin
        if (width_reg == '0) begin
            width_cl = COL_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            width_cl = COL_W'(MAX_WIDTH);
        end else begin
            width_cl = COL_W'(width_reg);
        end
        if (height_reg == '0) begin
            height_cl = ROW_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            height_cl = ROW_W'(MAX_HEIGHT);
        end else begin
            height_cl = ROW_W'(height_reg);
        end
    end

    // keep room for the item in flight as well as the queued ones
    assign s_ready = ((CNT_W+1)'(q_count) + (CNT_W+1)'(s1_valid_reg))
                     < (CNT_W+1)'(QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;

    assign col_last = (col_reg == width_cl + COL_W'(3));
    assign row_last = (row_reg == height_cl + ROW_W'(3));

    always_comb begin
        col_next = col_reg + COL_W'(1);
        row_next = row_reg;
        if (col_last) begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (cfg_we) begin
                if (cfg_index == CFG_IDX_WIDTH) begin
                    width_reg <= cfg_wdata[WIDTH_REG_W-1:0];
                end else begin
                    height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                end
                col_reg <= '0;
                row_reg <= '0;
            end else if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg  <= col_reg;
            s1_pix_reg  <= {s_blue_in, s_green_in, s_red_in};
            s1_emit_reg <= (row_reg >= ROW_W'(4)) && (col_reg >= COL_W'(4));
            s1_last_reg <= row_last && col_last;
        end
        if (s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

    // one ram per stored line; line k takes the column of line k+1
    for (genvar k = 0; k < LINE_ROWS; k++) begin : g_line
        mf5_ram #(
            .WIDTH($bits(pix_t)),
            .DEPTH(LINE_LEN)
        ) u_line (
            .aclk (aclk),
            .we   (s1_valid_reg),
            .waddr(s1_col_reg),
            .wdata(colv[k+1]),
            .re   (accept),
            .raddr(col_reg),
            .rdata(colv[k])
        );
    end
    assign colv[LINE_ROWS] = s1_pix_reg;

    always_comb begin
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 4; c++) begin
                win_next[r*5+c] = win_reg[r*5+c+1];
            end
            win_next[r*5+4] = colv[r];
        end
    end

    assign push           = s1_valid_reg && s1_emit_reg;
    assign push_item.win  = win_next;
    assign push_item.last = s1_last_reg;

    `MF5_ASSERT_NEXT(a_accept_to_s1, aclk, aresetn, accept, s1_valid_reg,
        "accepted pixel did not reach the window stage")

endmodule

`default_nettype wire

@@ rtl/mf5_queue.sv @@
// ----------------------------------------------------------------------------
// mf5_queue
// short fifo of full windows between the window builder and the sorter
// ----------------------------------------------------------------------------
`default_nettype none

module mf5_queue
    import mf5_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  win_item_t                         push_item,
    input  wire logic                         pop,
    output logic                              q_valid,
    output win_item_t                         q_item,
    output logic [$clog2(DEPTH+1)-1:0]        q_count
);

    `include "median_filter_5x5_rgb_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    win_item_t                 buf_reg [DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]          count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_item  = buf_reg[rd_ptr_reg];
    assign q_count = count_reg;

    `MF5_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push && !pop,
        32'(count_reg) < DEPTH, "window queue overflow")
    `MF5_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, count_reg != '0,
        "window queue underflow")

endmodule

`default_nettype wire

@@ rtl/mf5_back.sv @@
// ----------------------------------------------------------------------------
// mf5_back
// pipelined 32-input odd-even merge sort per channel, median out
// ----------------------------------------------------------------------------
`default_nettype none

module mf5_back
    import mf5_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    input  win_item_t       q_item,
    output logic            pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_red_out,
    output logic [7:0]      m_green_out,
    output logic [7:0]      m_blue_out,
    output logic            m_last_pixel
);

    `include "median_filter_5x5_rgb_macros.svh"

    rgb_vec_t             stg_reg   [SORT_STAGES+1];
    logic                 last_reg  [SORT_STAGES+1];
    logic [SORT_STAGES:0] valid_reg;
    rgb_vec_t             layer_out [SORT_STAGES];
    rgb_vec_t             load_vec;
    logic                 en;

    // whole pipe moves together; stalls only when the result is held
    assign en  = !valid_reg[SORT_STAGES] || m_ready;
    assign pop = en && q_valid;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int i = 0; i < WIN_SIZE; i++) begin
                load_vec[c][i] = q_item.win[i][8*c +: 8];
            end
            for (int i = WIN_SIZE; i < SORT_N; i++) begin
                load_vec[c][i] = PAD_VALUE;
            end
        end
    end

    for (genvar s = 0; s < SORT_STAGES; s++) begin : g_stage
        localparam int P = stage_p(s);
        localparam int K = stage_k(s);
        localparam int R = K % P;
        for (genvar c = 0; c < 3; c++) begin : g_chan
            for (genvar a = 0; a < SORT_N; a++) begin : g_elem
                localparam bit IS_LO = (a >= R) && (((a - R) % (2 * K)) < K)
                                       && (a + K < SORT_N)
                                       && ((a / (2 * P)) == ((a + K) / (2 * P)));
                localparam bit IS_HI = (a - K >= R) && (((a - K - R) % (2 * K)) < K)
                                       && ((a / (2 * P)) == ((a - K) / (2 * P)));
                if (IS_LO) begin : g_lo
                    assign layer_out[s][c][a] =
                        (stg_reg[s][c][a] < stg_reg[s][c][a+K]) ?
                        stg_reg[s][c][a] : stg_reg[s][c][a+K];
                end else if (IS_HI) begin : g_hi
                    assign layer_out[s][c][a] =
                        (stg_reg[s][c][a-K] < stg_reg[s][c][a]) ?
                        stg_reg[s][c][a] : stg_reg[s][c][a-K];
                end else begin : g_pass
                    assign layer_out[s][c][a] = stg_reg[s][c][a];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[SORT_STAGES-1:0], q_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0]  <= load_vec;
            last_reg[0] <= q_item.last;
            for (int s = 0; s < SORT_STAGES; s++) begin
                stg_reg[s+1]  <= layer_out[s];
                last_reg[s+1] <= last_reg[s];
            end
        end
    end

    assign m_valid      = valid_reg[SORT_STAGES];
    assign m_red_out    = stg_reg[SORT_STAGES][0][MEDIAN_RANK];
    assign m_green_out  = stg_reg[SORT_STAGES][1][MEDIAN_RANK];
    assign m_blue_out   = stg_reg[SORT_STAGES][2][MEDIAN_RANK];
    assign m_last_pixel = last_reg[SORT_STAGES];

    `MF5_ASSERT_IMPL(a_pop_needs_item, aclk, aresetn, pop, q_valid,
        "sorter loaded from an empty queue")

endmodule

`default_nettype wire
